// ===== rtl/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types and constants for the looped sample position stepper: voice
// entry layout, opcodes, loop modes and the modulo unit handshake.
// ----------------------------------------------------------------------------
package lsps_pkg;

  // Voice memory geometry
  localparam int unsigned VOICES           = 32;
  localparam int unsigned VIDX_W           = $clog2(VOICES);
  localparam int unsigned MAX_SAMPLE_BYTES = 4194304;

  // Field widths
  localparam int unsigned CH_W   = 5;
  localparam int unsigned POS_W  = 22;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned BOFS_W = 23;
  localparam int unsigned DIVD_W = 23;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;

  // Register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned CIU_W      = 6;
  localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(8);
  localparam logic [APB_ADDR_W-3:0] REG_CHANNELS_IN_USE = '0;

  // Loop end limits in samples
  localparam logic [POS_W-1:0] LIMIT_NARROW = POS_W'(MAX_SAMPLE_BYTES - 1);
  localparam logic [POS_W-1:0] LIMIT_WIDE   = POS_W'((MAX_SAMPLE_BYTES - 1) / 2);

  // Sample type bits
  localparam int unsigned TYPE_WIDE_BIT = 4;

  typedef enum logic [1:0] {
    OP_TRIGGER  = 2'd0,
    OP_SET_RATE = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } lsps_op_e;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_PINGPONG = 2'd2
  } lsps_mode_e;

  // One voice memory word
  typedef struct packed {
    logic                active;
    logic                back;
    logic                wide;
    lsps_mode_e          mode;
    logic [POS_W-1:0]    end_pos;
    logic [POS_W-1:0]    loop_len;
    logic [POS_W-1:0]    loop_start;
    logic [RATE_W-1:0]   rate;
    logic [FRAC_W-1:0]   frac;
    logic [POS_W-1:0]    pos;
  } voice_t;

  // Modulo unit request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [POS_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/lsps_mod.sv =====
// ----------------------------------------------------------------------------
// lsps_mod
// Restoring remainder unit: one dividend bit per cycle from start until all
// DIVD_W bits are in, then a one-cycle done pulse.
// ----------------------------------------------------------------------------
module lsps_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsps_pkg::mod_req_t req_i,
  output lsps_pkg::mod_rsp_t rsp_o
);
  import lsps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] num_q;
  logic [POS_W-1:0]  div_q;
  logic [POS_W-1:0]  rem_q;
  logic [POS_W:0]    trial;
  logic [POS_W-1:0]  rem_d;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, num_q[DIVD_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = POS_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = POS_W'(trial);
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIVD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/looped_sample_position_stepper.sv =====
// ----------------------------------------------------------------------------
// looped_sample_position_stepper
// Per-voice 22.16 sample position generator with none, forward and pingpong
// loops. Voice state lives in a 32-entry synchronous memory, read at accept
// and written back when the result beat is loaded.
//
//   channel   dir  beat content
//   s_axis    in   tuser: opcode; tdata: channel..step_rate
//   m_axis    out  tdata: voice, playing, sample_position, byte_offset
//   apb       in   channels_in_use at byte address 0
//
// An item is read, computed and written back. A tick that wraps at a
// loop end or reverses at the loop start adds a wrap step; with a loop length
// of two or more that step waits on the remainder unit, one bit per cycle.
// One item is in flight at a time; the next is taken once the previous one
// is written back, while its result may still wait in the output register.
// Reset clears the valid bits of the voice memory; an entry never written
// reads as all zero. m_axis stalls hold the next item in its write back.
// ----------------------------------------------------------------------------
module looped_sample_position_stepper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis tuser: opcode[1:0]
  // s_axis tdata: channel[4:0], sample_present[5], length_bytes[27:6],
  //   loop_start_bytes[49:28], loop_length_bytes[71:50], sample_type[79:72],
  //   play_offset[101:80], step_rate[133:102]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lsps_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic [lsps_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // m_axis tdata: voice[4:0], playing[5], sample_position[27:6],
  //   byte_offset[50:28]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lsps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsps_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lsps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lsps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import lsps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_WRAP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    WRAP_BACK,
    WRAP_LOOP,
    WRAP_PINGPONG
  } wrap_kind_e;

  state_e                 state_q;
  logic [CIU_W-1:0]       ciu_q;
  logic [VOICES-1:0]      vld_q;
  logic                   rd_vld_q;
  voice_t                 voice_mem [VOICES];
  voice_t                 rd_q;
  voice_t                 cur;
  voice_t                 ent_q;
  voice_t                 calc_ent;
  voice_t                 wrap_ent;
  logic [IN_DATA_W-1:0]   item_data_q;
  logic [IN_USER_W-1:0]   item_user_q;
  wrap_kind_e             kind_q;
  wrap_kind_e             calc_kind;
  logic                   use_div_q;
  logic                   calc_use_div;
  logic                   need_wrap;
  logic [DIVD_W-1:0]      calc_dvd;
  logic                   m_valid_q;
  logic [OUT_DATA_W-1:0]  m_data_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   wrap_ready;
  logic [VIDX_W-1:0]      in_idx;
  logic [VIDX_W-1:0]      wr_idx;
  logic                   voice_ok;
  logic                   tick_en;
  logic                   cfg_we;

  // Item fields
  lsps_op_e               f_op;
  logic [CH_W-1:0]        f_ch;
  logic                   f_present;
  logic [POS_W-1:0]       f_len;
  logic [POS_W-1:0]       f_ls;
  logic [POS_W-1:0]       f_ll;
  logic [TYPE_W-1:0]      f_type;
  logic [POS_W-1:0]       f_off;
  logic [RATE_W-1:0]      f_rate;

  // Trigger and tick temporaries
  logic                   t_wide;
  logic [POS_W-1:0]       t_len;
  logic [POS_W-1:0]       t_ls;
  logic [POS_W-1:0]       t_ll;
  logic [POS_W-1:0]       t_limit;
  lsps_mode_e             t_mode;
  logic [POS_W-1:0]       t_end;
  logic [RATE_W-1:0]      acc_sum;
  logic [FRAC_W-1:0]      step;
  logic [POS_W+1:0]       back_bound;
  logic [DIVD_W-1:0]      fwd_sum;
  logic [POS_W-1:0]       rem_sel;

  // Result temporaries
  logic                   r_playing;
  logic [POS_W-1:0]       r_pos;
  logic [BOFS_W-1:0]      r_bofs;

  assign f_op      = lsps_op_e'(item_user_q);
  assign f_ch      = item_data_q[4:0];
  assign f_present = item_data_q[5];
  assign f_len     = item_data_q[27:6];
  assign f_ls      = item_data_q[49:28];
  assign f_ll      = item_data_q[71:50];
  assign f_type    = item_data_q[79:72];
  assign f_off     = item_data_q[101:80];
  assign f_rate    = item_data_q[133:102];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign in_idx   = VIDX_W'(s_axis_tdata[4:0]);
  assign wr_idx   = VIDX_W'(f_ch);
  assign voice_ok = 32'(f_ch) < VOICES;
  assign tick_en  = CIU_W'(f_ch) < ciu_q;
  assign cur      = rd_vld_q ? rd_q : '0;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_CHANNELS_IN_USE);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_CHANNELS_IN_USE) ?
                  APB_DATA_W'(ciu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ciu_q <= CIU_RESET;
    end else if (cfg_we) begin
      ciu_q <= pwdata[CIU_W-1:0];
    end
  end

  // Trigger: halve for sixteen-bit, clip the loop, pick the end
  always_comb begin
    t_wide  = f_type[TYPE_WIDE_BIT];
    t_len   = t_wide ? (f_len >> 1) : f_len;
    t_ls    = t_wide ? (f_ls >> 1) : f_ls;
    t_ll    = t_wide ? (f_ll >> 1) : f_ll;
    t_limit = t_wide ? LIMIT_WIDE : LIMIT_NARROW;
    if (t_ll != '0) begin
      if (t_ls >= t_limit) begin
        t_ll = '0;
      end else if (t_ll > t_limit - t_ls) begin
        t_ll = t_limit - t_ls;
      end
    end
    if (t_ll == '0 || f_type[1:0] == 2'd0) begin
      t_mode = MODE_NONE;
    end else if (f_type[1:0] == 2'd2) begin
      t_mode = MODE_PINGPONG;
    end else begin
      t_mode = MODE_FORWARD;
    end
    t_end = (t_mode != MODE_NONE) ? (t_ls + t_ll) : t_len;
  end

  // Compute the updated entry for the current item
  always_comb begin
    calc_ent     = cur;
    need_wrap    = 1'b0;
    calc_kind    = WRAP_LOOP;
    calc_dvd     = '0;
    acc_sum      = RATE_W'(cur.frac) + cur.rate;
    step         = acc_sum[RATE_W-1:FRAC_W];
    back_bound   = (POS_W+2)'(cur.loop_start) + (POS_W+2)'(step);
    fwd_sum      = DIVD_W'(cur.pos) + DIVD_W'(step);
    case (f_op)
      OP_TRIGGER: begin
        if (!f_present || f_len == '0) begin
          calc_ent.active = 1'b0;
        end else begin
          calc_ent.end_pos    = t_end;
          calc_ent.loop_start = t_ls;
          calc_ent.loop_len   = t_ll;
          calc_ent.pos        = f_off;
          calc_ent.frac       = '0;
          calc_ent.mode       = t_mode;
          calc_ent.wide       = t_wide;
          calc_ent.back       = 1'b0;
          calc_ent.active     = f_off < t_end;
        end
      end
      OP_SET_RATE: begin
        calc_ent.rate = f_rate;
      end
      OP_TICK: begin
        if (tick_en && cur.active) begin
          calc_ent.frac = acc_sum[FRAC_W-1:0];
          if (step != '0) begin
            if (cur.back) begin
              // Moving back: reflect off the loop start
              if ((POS_W+2)'(cur.pos) <= back_bound) begin
                calc_ent.back = 1'b0;
                need_wrap     = 1'b1;
                calc_kind     = WRAP_BACK;
                calc_dvd      = DIVD_W'(back_bound - (POS_W+2)'(cur.pos));
              end else begin
                calc_ent.pos = POS_W'((POS_W+2)'(cur.pos) - (POS_W+2)'(step)
                                      - (POS_W+2)'(1));
              end
            end else if (fwd_sum >= DIVD_W'(cur.end_pos)) begin
              if (cur.mode == MODE_NONE) begin
                calc_ent.active = 1'b0;
              end else begin
                need_wrap = 1'b1;
                calc_kind = (cur.mode == MODE_PINGPONG) ? WRAP_PINGPONG : WRAP_LOOP;
                calc_dvd  = fwd_sum - DIVD_W'(cur.end_pos);
              end
            end else begin
              calc_ent.pos = POS_W'(fwd_sum);
            end
          end
        end
      end
      default: begin
        calc_ent = cur;
      end
    endcase
    calc_use_div = need_wrap && (cur.loop_len[POS_W-1:1] != '0);
  end

  // Remainder unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  assign mod_req.start    = (state_q == S_CALC) && calc_use_div;
  assign mod_req.dividend = calc_dvd;
  assign mod_req.divisor  = cur.loop_len;

  lsps_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Land the wrapped position
  assign wrap_ready = !use_div_q || mod_rsp.done;
  assign rem_sel    = use_div_q ? mod_rsp.rem : '0;

  always_comb begin
    wrap_ent = ent_q;
    case (kind_q)
      WRAP_PINGPONG: begin
        wrap_ent.pos  = ent_q.end_pos - POS_W'(1) - rem_sel;
        wrap_ent.back = 1'b1;
      end
      WRAP_BACK, WRAP_LOOP: begin
        wrap_ent.pos = ent_q.loop_start + rem_sel;
      end
      default: begin
        wrap_ent = ent_q;
      end
    endcase
  end

  // Result beat
  always_comb begin
    r_playing = voice_ok && ent_q.active;
    r_pos     = voice_ok ? ent_q.pos : '0;
    if (!r_playing) begin
      r_bofs = '1;
    end else if (ent_q.wide) begin
      r_bofs = {r_pos, 1'b0};
    end else begin
      r_bofs = {1'b0, r_pos};
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      vld_q     <= '0;
    end else begin
      // Load a finished beat, drop a taken one
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            rd_vld_q <= vld_q[in_idx];
            state_q  <= S_CALC;
          end
        end
        S_CALC: begin
          state_q <= need_wrap ? S_WRAP : S_DONE;
        end
        S_WRAP: begin
          if (wrap_ready) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (voice_ok) begin
              vld_q[wr_idx] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Voice memory, item capture and work registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_data_q <= s_axis_tdata;
      item_user_q <= s_axis_tuser;
      rd_q        <= voice_mem[in_idx];
    end
    if (state_q == S_CALC) begin
      ent_q     <= calc_ent;
      kind_q    <= calc_kind;
      use_div_q <= calc_use_div;
    end
    if (state_q == S_WRAP && wrap_ready) begin
      ent_q <= wrap_ent;
    end
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {(OUT_DATA_W-BOFS_W-POS_W-1-CH_W)'(0), r_bofs, r_pos, r_playing, f_ch};
      if (voice_ok) begin
        voice_mem[wr_idx] <= ent_q;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/lsps_checker.sv =====
// ----------------------------------------------------------------------------
// lsps_checker
// Port-level checks for the looped sample position stepper, bound to the
// top level.
// ----------------------------------------------------------------------------
module lsps_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [lsps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                                psel,
  input logic                                pready
);
  import lsps_pkg::*;

  logic              o_playing;
  logic [POS_W-1:0]  o_pos;
  logic [BOFS_W-1:0] o_bofs;

  assign o_playing = m_axis_tdata[5];
  assign o_pos     = m_axis_tdata[27:6];
  assign o_bofs    = m_axis_tdata[50:28];

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // Silent voice reports a byte offset of minus one
  a_idle_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !o_playing |-> o_bofs == '1)
    else $error("inactive voice with a byte offset");

  // Playing voice reports its position, plain or doubled
  a_play_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_playing |->
      (o_bofs == {1'b0, o_pos}) || (o_bofs == {o_pos, 1'b0}))
    else $error("byte offset does not match position");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("register access stalled");

endmodule

bind looped_sample_position_stepper lsps_checker u_lsps_checker (.*);
